@@ design/cvb_pkg.sv @@
// Shared types and constants of the checkerboard volume blend core.
package cvb_pkg;

    localparam int VALUE_W   = 16;  // voxel and window bound width
    localparam int PIX_W     = 8;   // output intensity width
    localparam int DIM_REG_W = 13;  // size register width
    localparam int CFG_IDX_W = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A_LOW       = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A_HIGH      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_B_LOW       = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_B_HIGH      = 8'd7;

    // Reset values of the registers
    localparam logic [DIM_REG_W-1:0] RST_SQUARE_SIZE = 13'd8;
    localparam logic [DIM_REG_W-1:0] RST_WIDTH       = 13'd256;
    localparam logic [DIM_REG_W-1:0] RST_HEIGHT      = 13'd256;
    localparam logic [DIM_REG_W-1:0] RST_DEPTH       = 13'd1;
    localparam logic [VALUE_W-1:0]   RST_LOW         = 16'd0;
    localparam logic [VALUE_W-1:0]   RST_HIGH        = 16'd255;

    typedef struct packed {
        logic [DIM_REG_W-1:0] square_size;
        logic [DIM_REG_W-1:0] width;
        logic [DIM_REG_W-1:0] height;
        logic [DIM_REG_W-1:0] depth;
        logic [VALUE_W-1:0]   a_low;
        logic [VALUE_W-1:0]   a_high;
        logic [VALUE_W-1:0]   b_low;
        logic [VALUE_W-1:0]   b_high;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_ZERO,
        JOB_FULL,
        JOB_DIVIDE
    } job_kind_t;

    // One classified item: kind, offset into the window, window span, source and last-voxel flag
    typedef struct packed {
        job_kind_t          kind;
        logic [VALUE_W-1:0] num;
        logic [VALUE_W-1:0] den;
        logic               source;
        logic               last_voxel;
    } job_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

@@ design/cvb_front.sv @@
// Front part: checker position counters, source choice and window classification.
module cvb_front
    import cvb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*VALUE_W-1:0] s_tdata,
    input  q_stat_t              q_stat,
    output logic                 job_push,
    output job_t                 job
);

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int EFF_W = POS_W + 1;

    logic [POS_W-1:0] col_pos_reg, row_pos_reg, slice_pos_reg;
    logic [POS_W-1:0] col_cnt_reg, row_cnt_reg, slice_cnt_reg;
    logic             col_par_reg, row_par_reg, slice_par_reg;

    logic [EFF_W-1:0] sq_eff, w_eff, h_eff, d_eff;
    logic             col_end, row_end, slice_end, last_voxel, source;
    logic             col_wrap, row_wrap, slice_wrap;

    logic signed [VALUE_W:0] v_x, lo_x, hi_x, hi_eff;
    logic signed [VALUE_W:0] num_x, den_x;

    function automatic logic [EFF_W-1:0] eff_size(input logic [DIM_REG_W-1:0] n);
        logic [31:0] n32;
        begin
            n32 = 32'(n);
            if (n == '0) begin
                return EFF_W'(1);
            end else if (n32 > 32'(MAX_DIM)) begin
                return EFF_W'(MAX_DIM);
            end else begin
                return EFF_W'(n32);
            end
        end
    endfunction

    // true when the incremented count reaches the limit (square edge or image size)
    function automatic logic reaches(input logic [POS_W-1:0] cnt,
                                     input logic [EFF_W-1:0] lim);
        begin
            return (EFF_W'(cnt) + EFF_W'(1)) >= lim;
        end
    endfunction

    assign sq_eff = eff_size(cfg.square_size);
    assign w_eff  = eff_size(cfg.width);
    assign h_eff  = eff_size(cfg.height);
    assign d_eff  = eff_size(cfg.depth);

    assign col_end    = reaches(col_pos_reg, w_eff);
    assign row_end    = reaches(row_pos_reg, h_eff);
    assign slice_end  = reaches(slice_pos_reg, d_eff);
    assign last_voxel = col_end && row_end && slice_end;

    assign col_wrap   = reaches(col_cnt_reg, sq_eff);
    assign row_wrap   = reaches(row_cnt_reg, sq_eff);
    assign slice_wrap = reaches(slice_cnt_reg, sq_eff);

    // parity sum of 0 or 2 picks A, i.e. the odd parity picks B
    assign source = col_par_reg ^ row_par_reg ^ slice_par_reg;

    assign s_tready = !q_stat.full;
    assign job_push = s_tvalid && s_tready;

    always_comb begin
        if (source) begin
            v_x  = {s_tdata[2*VALUE_W-1], s_tdata[2*VALUE_W-1:VALUE_W]};
            lo_x = {cfg.b_low[VALUE_W-1], cfg.b_low};
            hi_x = {cfg.b_high[VALUE_W-1], cfg.b_high};
        end else begin
            v_x  = {s_tdata[VALUE_W-1], s_tdata[VALUE_W-1:0]};
            lo_x = {cfg.a_low[VALUE_W-1], cfg.a_low};
            hi_x = {cfg.a_high[VALUE_W-1], cfg.a_high};
        end
        // degenerate window: high equal to low widens by one
        hi_eff = (hi_x == lo_x) ? (lo_x + 17'sd1) : hi_x;
        num_x  = v_x - lo_x;
        den_x  = hi_eff - lo_x;

        job.source     = source;
        job.last_voxel = last_voxel;
        job.num        = num_x[VALUE_W-1:0];
        job.den        = den_x[VALUE_W-1:0];
        priority if (v_x <= lo_x) begin
            job.kind = JOB_ZERO;
        end else if (v_x >= hi_eff) begin
            job.kind = JOB_FULL;
        end else begin
            job.kind = JOB_DIVIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            slice_pos_reg <= '0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            slice_cnt_reg <= '0;
            col_par_reg   <= 1'b0;
            row_par_reg   <= 1'b0;
            slice_par_reg <= 1'b0;
        end else if (job_push) begin
            if (last_voxel) begin
                col_pos_reg   <= '0;
                row_pos_reg   <= '0;
                slice_pos_reg <= '0;
                col_cnt_reg   <= '0;
                row_cnt_reg   <= '0;
                slice_cnt_reg <= '0;
                col_par_reg   <= 1'b0;
                row_par_reg   <= 1'b0;
                slice_par_reg <= 1'b0;
            end else if (!col_end) begin
                col_pos_reg <= col_pos_reg + POS_W'(1);
                col_cnt_reg <= col_wrap ? '0 : col_cnt_reg + POS_W'(1);
                col_par_reg <= col_par_reg ^ col_wrap;
            end else begin
                col_pos_reg <= '0;
                col_cnt_reg <= '0;
                col_par_reg <= 1'b0;
                if (!row_end) begin
                    row_pos_reg <= row_pos_reg + POS_W'(1);
                    row_cnt_reg <= row_wrap ? '0 : row_cnt_reg + POS_W'(1);
                    row_par_reg <= row_par_reg ^ row_wrap;
                end else begin
                    row_pos_reg   <= '0;
                    row_cnt_reg   <= '0;
                    row_par_reg   <= 1'b0;
                    slice_pos_reg <= slice_pos_reg + POS_W'(1);
                    slice_cnt_reg <= slice_wrap ? '0 : slice_cnt_reg + POS_W'(1);
                    slice_par_reg <= slice_par_reg ^ slice_wrap;
                end
            end
        end
    end

endmodule

@@ design/cvb_queue.sv @@
// Short job queue between the front and back parts.
module cvb_queue
    import cvb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    job_in,
    input  logic    pop,
    output job_t    job_out,
    output q_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign job_out    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ design/cvb_back.sv @@
// Back part: restoring divider for in-window voxels and the output register.
module cvb_back
    import cvb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  q_stat_t          q_stat,
    input  job_t             job,
    output logic             job_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,
    output logic [0:0]       m_tuser,
    output logic             m_tlast
);

    localparam int REM_W  = PIX_W + VALUE_W;
    localparam int STEP_W = $clog2(PIX_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [REM_W-1:0]  rem_reg, dsh_reg;
    logic [PIX_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              src_reg, last_reg;
    logic              m_valid_reg;
    logic [PIX_W-1:0]  m_pixel_reg;
    logic              m_src_reg, m_last_reg;

    logic              out_free, ge, load_out;
    logic [REM_W-1:0]  num_w, prod;

    assign out_free = !m_valid_reg || m_tready;
    assign job_pop  = (state_reg == ST_IDLE) && q_stat.valid &&
                      ((job.kind == JOB_DIVIDE) || out_free);

    // output register takes a new item this cycle
    assign load_out = ((state_reg == ST_IDLE) && job_pop && (job.kind != JOB_DIVIDE)) ||
                      ((state_reg == ST_DONE) && out_free);

    // 255 * offset as a shift and subtract
    assign num_w = REM_W'(job.num);
    assign prod  = (num_w << PIX_W) - num_w;
    assign ge    = (rem_reg >= dsh_reg);

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_pixel_reg;
    assign m_tuser[0] = m_src_reg;
    assign m_tlast    = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_pop) begin
                        if (job.kind == JOB_DIVIDE) begin
                            rem_reg   <= prod;
                            dsh_reg   <= REM_W'(job.den) << (PIX_W - 1);
                            quo_reg   <= '0;
                            step_reg  <= STEP_W'(PIX_W - 1);
                            src_reg   <= job.source;
                            last_reg  <= job.last_voxel;
                            state_reg <= ST_DIVIDE;
                        end else begin
                            m_pixel_reg <= (job.kind == JOB_FULL) ? PIX_MAX : '0;
                            m_src_reg   <= job.source;
                            m_last_reg  <= job.last_voxel;
                        end
                    end
                end
                ST_DIVIDE: begin
                    // one quotient bit per cycle, most significant first
                    if (ge) begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    quo_reg  <= {quo_reg[PIX_W-2:0], ge};
                    dsh_reg  <= dsh_reg >> 1;
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_pixel_reg <= quo_reg;
                        m_src_reg   <= src_reg;
                        m_last_reg  <= last_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ design/checkerboard_volume_blend_core.sv @@
// Checkerboard compositing of two co-located voxel streams with a per-image intensity window.
// Voxel pairs arrive in raster order (x fastest); each item yields one 8-bit pixel, the chosen
// image on tuser and tlast on the final voxel of the volume. The front part takes an item every
// cycle while its two-entry job queue has room. Voxels that fall at or beyond a window bound
// appear on the output in the cycle after they are popped; voxels inside the window go through a
// shared restoring divider that yields one quotient bit per cycle, so such an item holds the back
// part through load, 8 quotient steps and hand-off before it takes the next item. Size registers
// of 0 act as 1 and sizes above MAX_DIM act as MAX_DIM. No clearing pass after reset.
module checkerboard_volume_blend_core
    import cvb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*VALUE_W-1:0] s_tdata,    // voxel_a, voxel_b
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,    // pixel
    output logic [0:0]           m_tuser,    // source
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data
);

    cfg_t    cfg_reg;
    job_t    job_in, job_out;
    logic    job_push, job_pop;
    q_stat_t q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.square_size <= RST_SQUARE_SIZE;
            cfg_reg.width       <= RST_WIDTH;
            cfg_reg.height      <= RST_HEIGHT;
            cfg_reg.depth       <= RST_DEPTH;
            cfg_reg.a_low       <= RST_LOW;
            cfg_reg.a_high      <= RST_HIGH;
            cfg_reg.b_low       <= RST_LOW;
            cfg_reg.b_high      <= RST_HIGH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SQUARE_SIZE: cfg_reg.square_size <= cfg_data[DIM_REG_W-1:0];
                REG_WIDTH:       cfg_reg.width       <= cfg_data[DIM_REG_W-1:0];
                REG_HEIGHT:      cfg_reg.height      <= cfg_data[DIM_REG_W-1:0];
                REG_DEPTH:       cfg_reg.depth       <= cfg_data[DIM_REG_W-1:0];
                REG_A_LOW:       cfg_reg.a_low       <= cfg_data;
                REG_A_HIGH:      cfg_reg.a_high      <= cfg_data;
                REG_B_LOW:       cfg_reg.b_low       <= cfg_data;
                REG_B_HIGH:      cfg_reg.b_high      <= cfg_data;
                default:         cfg_reg             <= cfg_reg;  // unknown index ignored
            endcase
        end
    end

    cvb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .job_push (job_push),
        .job      (job_in)
    );

    cvb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .job_in  (job_in),
        .pop     (job_pop),
        .job_out (job_out),
        .stat    (q_stat)
    );

    cvb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .job      (job_out),
        .job_pop  (job_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // back part never pops an empty queue
    a_pop_needs_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> q_stat.valid)
        else $error("job popped from empty queue");

    // front part never pushes into a full queue
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> !q_stat.full)
        else $error("job pushed into full queue");

    // a full queue cannot report empty
    a_full_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> q_stat.valid)
        else $error("queue status inconsistent");

    // a queue that is full and not drained stays full
    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.full && !job_pop) |=> q_stat.full)
        else $error("queue lost a job");
`endif

endmodule
